FILE: rtl/core/nonc_pkg.sv
// Shared types and constants for the natural-order name comparator.
package nonc_pkg;

   localparam int NAME_LEN_DEFAULT = 256;

   localparam logic OP_FIRST  = 1'b0;
   localparam logic OP_SECOND = 1'b1;

   localparam logic signed [1:0] ORDER_LESS    = 2'sb11;
   localparam logic signed [1:0] ORDER_EQUAL   = 2'sb00;
   localparam logic signed [1:0] ORDER_GREATER = 2'sb01;

   localparam logic [7:0] CHAR_END    = 8'h00;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   typedef struct packed {
      logic       opcode;
      logic [7:0] name_byte;
   } nonc_req_type;

   typedef struct packed {
      logic signed [1:0] order;
      logic              truncated;
   } nonc_rsp_type;

   typedef struct packed {
      logic ended;
      logic full;
   } nonc_store_status_type;

   typedef struct packed {
      logic              done;
      logic signed [1:0] order;
   } nonc_walk_type;

endpackage

FILE: rtl/core/nonc_store.sv
// Byte store for one name: memory, fill count and end flag.
module nonc_store #(
   parameter int NAME_LEN = nonc_pkg::NAME_LEN_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  take,
   input  logic [7:0]                            take_byte,
   input  logic                                  clear,
   input  logic [$clog2(NAME_LEN + 1) - 1:0]     rd_addr,
   output logic [$clog2(NAME_LEN + 1) - 1:0]     count,
   output logic [7:0]                            rdata,
   output nonc_pkg::nonc_store_status_type       status
);
   import nonc_pkg::*;

   localparam int CW = $clog2(NAME_LEN + 1);
   localparam int AW = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;

   logic [7:0]    mem [NAME_LEN];
   logic [7:0]    rdata_ff;
   logic [CW-1:0] count_ff, count_in;
   logic          ended_ff, ended_in;
   logic          full;
   logic          wr_en;

   assign full  = (count_ff == CW'(NAME_LEN));
   assign wr_en = take && !ended_ff && (take_byte != CHAR_END) && !full;

   always_comb begin
      count_in = count_ff;
      ended_in = ended_ff;
      if (clear) begin
         count_in = '0;
         ended_in = 1'b0;
      end else if (take && !ended_ff) begin
         if (take_byte == CHAR_END) begin
            ended_in = 1'b1;
         end else if (!full) begin
            count_in = count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ended_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ended_ff <= ended_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= take_byte;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr[AW-1:0]];
   end

   assign count        = count_ff;
   assign rdata        = rdata_ff;
   assign status.ended = ended_ff;
   assign status.full  = full;

   a_ended_holds: assert property (@(posedge clock) disable iff (reset)
      take && ended_ff && !clear |=> ended_ff && $stable(count_ff))
      else $error("store changed after its name ended");

endmodule

FILE: rtl/core/nonc_walker.sv
// Compare sequencer: walks both stored names, one step per cycle.
module nonc_walker #(
   parameter int NAME_LEN = nonc_pkg::NAME_LEN_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  ack,
   input  logic [$clog2(NAME_LEN + 1) - 1:0]     count_a,
   input  logic [$clog2(NAME_LEN + 1) - 1:0]     count_b,
   input  logic [7:0]                            rdata_a,
   input  logic [7:0]                            rdata_b,
   output logic [$clog2(NAME_LEN + 1) - 1:0]     rd_addr_a,
   output logic [$clog2(NAME_LEN + 1) - 1:0]     rd_addr_b,
   output nonc_pkg::nonc_walk_type               walk
);
   import nonc_pkg::*;

   localparam int CW = $clog2(NAME_LEN + 1);

   typedef enum logic [5:0] {
      W_IDLE = 6'b000001,
      W_MAIN = 6'b000010,
      W_SKIP = 6'b000100,
      W_RUN  = 6'b001000,
      W_TIE  = 6'b010000,
      W_DONE = 6'b100000
   } walk_state_type;

   walk_state_type    state_ff, state_in;
   logic [CW-1:0]     i_ff, i_in, j_ff, j_in;
   logic signed [1:0] diff_ff, diff_in;
   logic signed [1:0] order_ff, order_in;
   logic [7:0]        ca, cb, fa, fb;
   logic              da, db;

   function automatic logic is_digit(input logic [7:0] c);
      return (c inside {[CHAR_ZERO:CHAR_NINE]});
   endfunction

   function automatic logic [7:0] fold(input logic [7:0] c);
      return (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) ? c + CASE_OFFSET : c;
   endfunction

   function automatic logic signed [1:0] sign_of(input logic [7:0] x, input logic [7:0] y);
      return (x < y) ? ORDER_LESS : ORDER_GREATER;
   endfunction

   assign ca = (i_ff < count_a) ? rdata_a : CHAR_END;
   assign cb = (j_ff < count_b) ? rdata_b : CHAR_END;
   assign fa = fold(ca);
   assign fb = fold(cb);
   assign da = is_digit(ca);
   assign db = is_digit(cb);

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      diff_in  = diff_ff;
      order_in = order_ff;
      case (state_ff)
         W_IDLE: begin
            i_in = '0;
            j_in = '0;
            if (start) begin
               state_in = W_MAIN;
            end
         end
         W_MAIN: begin
            if (ca == CHAR_END || cb == CHAR_END) begin
               if (ca != CHAR_END) begin
                  order_in = ORDER_GREATER;
                  state_in = W_DONE;
               end else if (cb != CHAR_END) begin
                  order_in = ORDER_LESS;
                  state_in = W_DONE;
               end else begin
                  i_in     = '0;
                  j_in     = '0;
                  state_in = W_TIE;
               end
            end else if (da && db) begin
               state_in = W_SKIP;
            end else if (fa != fb) begin
               order_in = sign_of(fa, fb);
               state_in = W_DONE;
            end else begin
               i_in = i_ff + CW'(1);
               j_in = j_ff + CW'(1);
            end
         end
         W_SKIP: begin
            if (ca == CHAR_ZERO) begin
               i_in = i_ff + CW'(1);
            end
            if (cb == CHAR_ZERO) begin
               j_in = j_ff + CW'(1);
            end
            if (ca != CHAR_ZERO && cb != CHAR_ZERO) begin
               diff_in  = ORDER_EQUAL;
               state_in = W_RUN;
            end
         end
         W_RUN: begin
            if (da && db) begin
               i_in = i_ff + CW'(1);
               j_in = j_ff + CW'(1);
               if (diff_ff == ORDER_EQUAL && ca != cb) begin
                  diff_in = sign_of(ca, cb);
               end
            end else if (da) begin
               order_in = ORDER_GREATER;
               state_in = W_DONE;
            end else if (db) begin
               order_in = ORDER_LESS;
               state_in = W_DONE;
            end else if (diff_ff != ORDER_EQUAL) begin
               order_in = diff_ff;
               state_in = W_DONE;
            end else begin
               state_in = W_MAIN;
            end
         end
         W_TIE: begin
            if (ca != cb) begin
               order_in = sign_of(ca, cb);
               state_in = W_DONE;
            end else if (ca == CHAR_END) begin
               order_in = ORDER_EQUAL;
               state_in = W_DONE;
            end else begin
               i_in = i_ff + CW'(1);
               j_in = j_ff + CW'(1);
            end
         end
         W_DONE: begin
            if (ack) begin
               i_in     = '0;
               j_in     = '0;
               state_in = W_IDLE;
            end
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff  <= diff_in;
      order_ff <= order_in;
   end

   // read address follows the next pointer so data lines up with the pointer
   assign rd_addr_a  = i_in;
   assign rd_addr_b  = j_in;
   assign walk.done  = (state_ff == W_DONE);
   assign walk.order = order_ff;

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != W_IDLE |-> (i_ff <= count_a) && (j_ff <= count_b))
      else $error("walk pointer ran past stored bytes");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == W_DONE && !ack |=> state_ff == W_DONE && $stable(order_ff))
      else $error("result lost before it was taken");

endmodule

FILE: rtl/core/natural_order_name_compare.sv
// Top level of the natural-order name comparator.
//  channel  ports        direction  transaction
//  req      req_*        in         one byte of the first or second name
//  rsp      rsp_*        out        order of the two names and truncation flag
// A name byte is taken whenever req_valid is high and req_stall is low while loading.
// The ending byte of the second name to end starts the walk. The walk makes one step
// per cycle, as each name memory has a single read port: it compares folded bytes,
// skips the leading zeros of digit runs and compares the runs, and on a tie makes a
// second pass over the raw bytes. The result is then loaded into the output register.
// req_stall is high from the cycle after the ending byte through the result load cycle.
// Reset clears counts and flags only; the memories are not cleared.
// A waiting result in the output register holds the walk in its last step.
module natural_order_name_compare #(
   parameter int NAME_LEN = nonc_pkg::NAME_LEN_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  nonc_pkg::nonc_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output nonc_pkg::nonc_rsp_type rsp_data
);
   import nonc_pkg::*;

   localparam int CW = $clog2(NAME_LEN + 1);

   nonc_store_status_type st_a, st_b, st_sel;
   nonc_walk_type         walk;
   nonc_rsp_type          rsp_data_ff, rsp_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  busy_ff, busy_in;
   logic                  overflow_ff, overflow_in;
   logic [CW-1:0]         count_a, count_b, rd_addr_a, rd_addr_b;
   logic [7:0]            rdata_a, rdata_b;
   logic                  accept, take_a, take_b, other_ended, end_now, start, ack;

   assign accept      = req_valid && !req_stall;
   assign take_a      = accept && (req_data.opcode == OP_FIRST);
   assign take_b      = accept && (req_data.opcode == OP_SECOND);
   assign st_sel      = (req_data.opcode == OP_SECOND) ? st_b : st_a;
   assign other_ended = (req_data.opcode == OP_SECOND) ? st_a.ended : st_b.ended;
   assign end_now     = accept && !st_sel.ended && (req_data.name_byte == CHAR_END);
   assign start       = end_now && other_ended;
   assign ack         = walk.done && (!rsp_valid_ff || !rsp_stall);

   nonc_store #(.NAME_LEN(NAME_LEN)) u_store_a (
      .clock     (clock),
      .reset     (reset),
      .take      (take_a),
      .take_byte (req_data.name_byte),
      .clear     (ack),
      .rd_addr   (rd_addr_a),
      .count     (count_a),
      .rdata     (rdata_a),
      .status    (st_a)
   );

   nonc_store #(.NAME_LEN(NAME_LEN)) u_store_b (
      .clock     (clock),
      .reset     (reset),
      .take      (take_b),
      .take_byte (req_data.name_byte),
      .clear     (ack),
      .rd_addr   (rd_addr_b),
      .count     (count_b),
      .rdata     (rdata_b),
      .status    (st_b)
   );

   nonc_walker #(.NAME_LEN(NAME_LEN)) u_walker (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .ack       (ack),
      .count_a   (count_a),
      .count_b   (count_b),
      .rdata_a   (rdata_a),
      .rdata_b   (rdata_b),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .walk      (walk)
   );

   always_comb begin
      busy_in      = busy_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && !st_sel.ended && req_data.name_byte != CHAR_END && st_sel.full) begin
         overflow_in = 1'b1;
      end
      if (start) begin
         busy_in = 1'b1;
      end
      if (ack) begin
         busy_in               = 1'b0;
         overflow_in           = 1'b0;
         rsp_valid_in          = 1'b1;
         rsp_data_in.order     = walk.order;
         rsp_data_in.truncated = overflow_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && !walk.done)
      else $error("walk did not take the pair");

   a_ack_clears: assert property (@(posedge clock) disable iff (reset)
      ack |=> rsp_valid_ff && !st_a.ended && !st_b.ended && !overflow_ff)
      else $error("pair state not cleared after result");

endmodule
